// File: src/rgb_hue_rotate_core_macros.svh
// Assertion macros shared by the hue rotation RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef RGB_HUE_ROTATE_CORE_MACROS_SVH
`define RGB_HUE_ROTATE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HROT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrot: check failed");
// next-cycle implication
`define HROT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrot: check failed");
`else
`define HROT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HROT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/hrot_pkg.sv
// Package for the hue rotation core: widths, sector codes, payload structs.
// No dependencies.
`default_nettype none
package hrot_pkg;

    localparam int CHANNEL_BITS  = 16;
    localparam int HUE_FRAC_BITS = 16;
    localparam int QUOT_BITS     = HUE_FRAC_BITS + 1;   // quotient may reach 1.0
    localparam int DIV_CELLS     = QUOT_BITS;
    localparam int SHIFT_WIDTH   = 18;
    localparam int SHIFT_LIMIT   = 65536;
    localparam int TURN_UNITS    = 6 << HUE_FRAC_BITS;
    localparam int POS_BITS      = $clog2(2 * TURN_UNITS) + 1;  // signed hue position
    localparam int BACK_STAGES   = 4;
    localparam int PIPE_LAT      = 1 + DIV_CELLS + BACK_STAGES;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_ADDR_BITS-1:0] REG_HUE_SHIFT = CFG_ADDR_BITS'(0);

    // hue sectors
    localparam logic [2:0] SEC_RG = 3'd0;
    localparam logic [2:0] SEC_GR = 3'd1;
    localparam logic [2:0] SEC_GB = 3'd2;
    localparam logic [2:0] SEC_BG = 3'd3;
    localparam logic [2:0] SEC_BR = 3'd4;
    localparam logic [2:0] SEC_RB = 3'd5;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
        logic [CHANNEL_BITS-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic [CHANNEL_BITS-1:0] alpha_out;
    } t_pix_out;

    // pixel context carried alongside the divider
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hi;
        logic [CHANNEL_BITS-1:0] lo;
        logic [CHANNEL_BITS-1:0] alpha;
        logic [2:0]              base;
        logic                    neg;
        logic                    gray;
    } t_div_ctx;

    // partial division state
    typedef struct packed {
        logic [CHANNEL_BITS:0]   rem;
        logic [QUOT_BITS-1:0]    quot;
        logic [CHANNEL_BITS-1:0] d;
    } t_div_work;

endpackage
`default_nettype wire

// File: src/rgb_hue_rotate_core.sv
// Top level of the RGBA hue rotation core: front end, divider cell row, back end.
// Depends on hrot_pkg, hrot_front, hrot_cell, hrot_back and the macros header.
//
// Usage:
//  - Pixel channel: a transaction is taken at each rising edge with start high
//    and busy low. busy is high only from reset until the first clock after
//    reset is released; from then on a pixel may be issued every cycle.
//  - Result channel: o_strobe marks one cycle in which o_pixel holds the
//    rotated pixel. The receiver cannot stall; it must take it in that cycle.
//  - Pipeline: one front register, one cell per quotient bit (17) in the
//    division row, then four back-end stages (hue position, rotate and
//    wrap, multiply, channel rebuild).
//  - Throughput is one pixel per clock; every cell hands its partial
//    remainder on to its neighbour each cycle, so up to 22 pixels are in flight.
//  - Configuration: APB write of hue_shift at byte address 0 (pwdata[17:0]);
//    65536 is a full turn, clamped to +-65536 in use. Write only while idle.
//  - Reset clears all valid flags and sets hue_shift to zero; pixels in
//    flight are dropped.
`default_nettype none
`include "rgb_hue_rotate_core_macros.svh"
module rgb_hue_rotate_core import hrot_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // pixel in
    input  wire logic                     start,
    output logic                          busy,
    input  wire t_pix_in                  i_pixel,
    // pixel out
    output logic                          o_strobe,
    output t_pix_out                      o_pixel,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    logic                          r_run;
    logic signed [SHIFT_WIDTH-1:0] r_hue_shift;
    logic                          cfg_wr;
    logic                          accept;

    // division row taps
    logic      cell_valid [DIV_CELLS+1];
    t_div_ctx  cell_ctx   [DIV_CELLS+1];
    t_div_work cell_work  [DIV_CELLS+1];

    assign accept = start && !busy;
    assign busy   = !r_run;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_HUE_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_hue_shift <= '0;
        end else begin
            r_run <= 1'b1;
            if (cfg_wr) begin
                r_hue_shift <= pwdata[SHIFT_WIDTH-1:0];
            end
        end
    end

    // register read, sign extended
    always_comb begin
        prdata = '0;
        if (paddr == REG_HUE_SHIFT) begin
            prdata = CFG_DATA_BITS'(r_hue_shift);
        end
    end

    hrot_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pix   (i_pixel),
        .o_valid (cell_valid[0]),
        .o_ctx   (cell_ctx[0]),
        .o_work  (cell_work[0])
    );

    // one quotient bit per cell, MSB first
    for (genvar gi = 0; gi < DIV_CELLS; gi++) begin : g_cell
        hrot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[gi]),
            .i_ctx   (cell_ctx[gi]),
            .i_work  (cell_work[gi]),
            .o_valid (cell_valid[gi+1]),
            .o_ctx   (cell_ctx[gi+1]),
            .o_work  (cell_work[gi+1])
        );
    end

    hrot_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cell_valid[DIV_CELLS]),
        .i_ctx       (cell_ctx[DIV_CELLS]),
        .i_quot      (cell_work[DIV_CELLS].quot),
        .i_d         (cell_work[DIV_CELLS].d),
        .i_hue_shift (r_hue_shift),
        .o_valid     (o_strobe),
        .o_pix       (o_pixel)
    );

    `HROT_ASSERT_IMPL(a_strobe_follows_accept, i_clk, i_rst_n, o_strobe,
        $past(accept, PIPE_LAT))
    `HROT_ASSERT_IMPL(a_alpha_carried, i_clk, i_rst_n, o_strobe,
        o_pixel.alpha_out == $past(i_pixel.alpha_in, PIPE_LAT))
    `HROT_ASSERT_NEXT(a_busy_stays_low, i_clk, i_rst_n, !busy, !busy)

endmodule
`default_nettype wire

// File: src/hrot_front.sv
// Front stage: max, min, hue sector base, signed difference and divisor.
// Depends on hrot_pkg.
`default_nettype none
module hrot_front import hrot_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_pix_in   i_pix,
    output logic           o_valid,
    output t_div_ctx       o_ctx,
    output t_div_work      o_work
);

    logic [CHANNEL_BITS-1:0] hi, lo, mag;
    logic signed [CHANNEL_BITS:0] num;
    t_div_ctx  n_ctx;
    t_div_work n_work;
    logic r_valid;
    t_div_ctx  r_ctx;
    t_div_work r_work;

    always_comb begin
        hi = i_pix.red_in;
        lo = i_pix.red_in;
        if (i_pix.green_in > hi) hi = i_pix.green_in;
        if (i_pix.blue_in  > hi) hi = i_pix.blue_in;
        if (i_pix.green_in < lo) lo = i_pix.green_in;
        if (i_pix.blue_in  < lo) lo = i_pix.blue_in;

        // red wins ties, then green
        if (i_pix.red_in == hi) begin
            n_ctx.base = SEC_RG;
            num = $signed({1'b0, i_pix.green_in}) - $signed({1'b0, i_pix.blue_in});
        end else if (i_pix.green_in == hi) begin
            n_ctx.base = SEC_GB;
            num = $signed({1'b0, i_pix.blue_in}) - $signed({1'b0, i_pix.red_in});
        end else begin
            n_ctx.base = SEC_BR;
            num = $signed({1'b0, i_pix.red_in}) - $signed({1'b0, i_pix.green_in});
        end
        mag = num[CHANNEL_BITS] ? CHANNEL_BITS'(-num) : num[CHANNEL_BITS-1:0];

        n_ctx.hi    = hi;
        n_ctx.lo    = lo;
        n_ctx.alpha = i_pix.alpha_in;
        n_ctx.neg   = num[CHANNEL_BITS];
        n_ctx.gray  = (hi == lo);

        n_work.rem  = {1'b0, mag};
        n_work.quot = '0;
        n_work.d    = hi - lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx  <= n_ctx;
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_work  = r_work;

endmodule
`default_nettype wire

// File: src/hrot_cell.sv
// One restoring-division cell: a compare-subtract giving one quotient bit.
// Depends on hrot_pkg.
`default_nettype none
module hrot_cell import hrot_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_div_ctx  i_ctx,
    input  wire t_div_work i_work,
    output logic           o_valid,
    output t_div_ctx       o_ctx,
    output t_div_work      o_work
);

    logic                    ge;
    logic [CHANNEL_BITS:0]   diff;
    t_div_work               n_work;
    logic                    r_valid;
    t_div_ctx                r_ctx;
    t_div_work               r_work;

    always_comb begin
        ge          = (i_work.rem >= {1'b0, i_work.d});
        diff        = ge ? (i_work.rem - {1'b0, i_work.d}) : i_work.rem;
        // remainder now below d, so the doubled value fits
        n_work.rem  = {diff[CHANNEL_BITS-1:0], 1'b0};
        n_work.quot = {i_work.quot[QUOT_BITS-2:0], ge};
        n_work.d    = i_work.d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx  <= i_ctx;
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_work  = r_work;

endmodule
`default_nettype wire

// File: src/hrot_back.sv
// Back end: hue position, rotation and wrap, f*(v-min), RGB rebuild.
// Depends on hrot_pkg and rgb_hue_rotate_core_macros.svh.
`default_nettype none
`include "rgb_hue_rotate_core_macros.svh"
module hrot_back import hrot_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire t_div_ctx                      i_ctx,
    input  wire logic [QUOT_BITS-1:0]          i_quot,
    input  wire logic [CHANNEL_BITS-1:0]       i_d,
    input  wire logic signed [SHIFT_WIDTH-1:0] i_hue_shift,
    output logic                               o_valid,
    output t_pix_out                           o_pix
);

    localparam logic signed [POS_BITS-1:0]    TURN_S    = POS_BITS'(TURN_UNITS);
    localparam logic signed [SHIFT_WIDTH-1:0] SHIFT_MAX = SHIFT_WIDTH'(SHIFT_LIMIT);
    localparam logic signed [SHIFT_WIDTH-1:0] SHIFT_MIN = -SHIFT_MAX;

    // stage A
    logic signed [POS_BITS-1:0]    qs, basev, raw, n_a_pos, sh_ext, n_a_shift6;
    logic signed [SHIFT_WIDTH-1:0] sc;
    logic                          r_a_valid;
    t_div_ctx                      r_a_ctx;
    logic [CHANNEL_BITS-1:0]       r_a_d;
    logic signed [POS_BITS-1:0]    r_a_pos, r_a_shift6;
    // stage B
    logic signed [POS_BITS-1:0]    sum, wrapped;
    logic                          r_b_valid;
    t_div_ctx                      r_b_ctx;
    logic [CHANNEL_BITS-1:0]       r_b_d;
    logic [2:0]                    r_b_sector;
    logic [HUE_FRAC_BITS-1:0]      r_b_frac;
    // stage C
    logic [HUE_FRAC_BITS+CHANNEL_BITS-1:0] prod;
    logic                          r_c_valid;
    t_div_ctx                      r_c_ctx;
    logic [CHANNEL_BITS-1:0]       r_c_d;
    logic [2:0]                    r_c_sector;
    logic [CHANNEL_BITS-1:0]       r_c_fd;
    // stage D
    logic [CHANNEL_BITS-1:0]       qv, tv;
    t_pix_out                      n_pix;
    logic                          r_d_valid;
    t_pix_out                      r_pix;

    // A: sector base plus signed fraction, negative hue folded up a turn
    always_comb begin
        qs      = $signed({{(POS_BITS-QUOT_BITS){1'b0}}, i_quot});
        basev   = $signed({{(POS_BITS-3-HUE_FRAC_BITS){1'b0}}, i_ctx.base,
                           {HUE_FRAC_BITS{1'b0}}});
        raw     = basev + (i_ctx.neg ? -qs : qs);
        n_a_pos = raw[POS_BITS-1] ? raw + TURN_S : raw;

        if (i_hue_shift > SHIFT_MAX)      sc = SHIFT_MAX;
        else if (i_hue_shift < SHIFT_MIN) sc = SHIFT_MIN;
        else                              sc = i_hue_shift;
        sh_ext     = POS_BITS'(sc);
        n_a_shift6 = (sh_ext <<< 2) + (sh_ext <<< 1);
    end

    // B: rotate and wrap into one turn
    always_comb begin
        sum = r_a_pos + r_a_shift6;
        if (sum[POS_BITS-1])   wrapped = sum + TURN_S;
        else if (sum >= TURN_S) wrapped = sum - TURN_S;
        else                    wrapped = sum;
    end

    // C: truncated f * (v - min)
    assign prod = r_b_frac * r_b_d;

    // D: rebuild channels from v, p, q, t
    always_comb begin
        qv = r_c_ctx.hi - r_c_fd;
        tv = r_c_ctx.lo + r_c_fd;
        n_pix.alpha_out = r_c_ctx.alpha;
        case (r_c_sector)
            SEC_RG: begin
                n_pix.red_out = r_c_ctx.hi; n_pix.green_out = tv; n_pix.blue_out = r_c_ctx.lo;
            end
            SEC_GR: begin
                n_pix.red_out = qv; n_pix.green_out = r_c_ctx.hi; n_pix.blue_out = r_c_ctx.lo;
            end
            SEC_GB: begin
                n_pix.red_out = r_c_ctx.lo; n_pix.green_out = r_c_ctx.hi; n_pix.blue_out = tv;
            end
            SEC_BG: begin
                n_pix.red_out = r_c_ctx.lo; n_pix.green_out = qv; n_pix.blue_out = r_c_ctx.hi;
            end
            SEC_BR: begin
                n_pix.red_out = tv; n_pix.green_out = r_c_ctx.lo; n_pix.blue_out = r_c_ctx.hi;
            end
            default: begin
                n_pix.red_out = r_c_ctx.hi; n_pix.green_out = r_c_ctx.lo; n_pix.blue_out = qv;
            end
        endcase
        if (r_c_ctx.gray) begin
            n_pix.red_out   = r_c_ctx.hi;
            n_pix.green_out = r_c_ctx.hi;
            n_pix.blue_out  = r_c_ctx.hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ctx    <= i_ctx;
        r_a_d      <= i_d;
        r_a_pos    <= n_a_pos;
        r_a_shift6 <= n_a_shift6;

        r_b_ctx    <= r_a_ctx;
        r_b_d      <= r_a_d;
        r_b_sector <= wrapped[HUE_FRAC_BITS+2:HUE_FRAC_BITS];
        r_b_frac   <= wrapped[HUE_FRAC_BITS-1:0];

        r_c_ctx    <= r_b_ctx;
        r_c_d      <= r_b_d;
        r_c_sector <= r_b_sector;
        r_c_fd     <= prod[HUE_FRAC_BITS+CHANNEL_BITS-1:HUE_FRAC_BITS];

        r_pix      <= n_pix;
    end

    assign o_valid = r_d_valid;
    assign o_pix   = r_pix;

    `HROT_ASSERT_IMPL(a_pos_in_turn, i_clk, i_rst_n, r_a_valid,
        !r_a_pos[POS_BITS-1] && (r_a_pos < TURN_S))
    `HROT_ASSERT_IMPL(a_sector_legal, i_clk, i_rst_n, r_b_valid, r_b_sector <= SEC_RB)
    `HROT_ASSERT_IMPL(a_fd_bounded, i_clk, i_rst_n, r_c_valid && !r_c_ctx.gray,
        r_c_fd <= r_c_d)

endmodule
`default_nettype wire
